FILE: rtl/dmc_pkg.sv
`default_nettype none

package dmc_pkg;

  localparam int WidthW      = 16;
  localparam int LevelCntW   = 5;
  localparam int OffsetW     = 37;
  localparam int RowW        = 20;
  localparam int SliceW      = 36;
  localparam int MulAW       = 20;
  localparam int MulBW       = 16;
  localparam int MulPW       = MulAW + MulBW;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NO_FCC   = 3'd1;
  localparam logic [2:0] ST_BAD_FCC  = 3'd2;
  localparam logic [2:0] ST_NO_LIN   = 3'd3;
  localparam logic [2:0] ST_NO_LVL   = 3'd4;

  localparam logic [31:0] CODE_DXT1 = 32'h3154_5844;
  localparam logic [31:0] CODE_DXT2 = 32'h3254_5844;
  localparam logic [31:0] CODE_DXT3 = 32'h3354_5844;
  localparam logic [31:0] CODE_DXT4 = 32'h3454_5844;
  localparam logic [31:0] CODE_DXT5 = 32'h3554_5844;
  localparam logic [31:0] CODE_DX10 = 32'h3031_5844;

  localparam logic [OffsetW-1:0] BASE_OFFSET = 37'd128;
  localparam logic [OffsetW-1:0] EXT_OFFSET  = 37'd148;

  localparam logic [7:0] BLOCK_BYTES_DXT1 = 8'd8;
  localparam logic [7:0] BLOCK_BYTES_DXTN = 8'd16;

  typedef struct packed {
    logic        fourcc_present;
    logic [31:0] fourcc_code;
    logic [7:0]  pix_format;
    logic        has_linear_size;
    logic [15:0] width;
    logic [15:0] height;
    logic [4:0]  mip_count;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  level;
    logic [36:0] level_offset;
    logic [19:0] row_size;
    logic [35:0] slice_size;
    logic        last;
  } out_t;

  // DXGI bits per pixel, 0 for formats with no entry
  function automatic logic [7:0] dxgi_bits(input logic [7:0] f);
    logic [7:0] b;
    b = 8'd0;
    if (f >= 8'd1 && f <= 8'd4) b = 8'd128;
    else if (f >= 8'd5 && f <= 8'd8) b = 8'd96;
    else if (f >= 8'd9 && f <= 8'd22) b = 8'd64;
    else if (f >= 8'd23 && f <= 8'd47) b = 8'd32;
    else if (f >= 8'd48 && f <= 8'd59) b = 8'd16;
    else if (f >= 8'd60 && f <= 8'd65) b = 8'd8;
    else if (f == 8'd66) b = 8'd1;
    else if (f >= 8'd67 && f <= 8'd69) b = 8'd32;
    else if (f >= 8'd70 && f <= 8'd72) b = 8'd4;
    else if (f >= 8'd73 && f <= 8'd78) b = 8'd8;
    else if (f >= 8'd79 && f <= 8'd81) b = 8'd4;
    else if (f >= 8'd82 && f <= 8'd84) b = 8'd8;
    else if (f >= 8'd85 && f <= 8'd86) b = 8'd16;
    else if (f >= 8'd87 && f <= 8'd93) b = 8'd32;
    else if (f >= 8'd94 && f <= 8'd99) b = 8'd8;
    else if (f >= 8'd100 && f <= 8'd101) b = 8'd32;
    else if (f == 8'd102) b = 8'd64;
    else if (f == 8'd103) b = 8'd12;
    else if (f >= 8'd104 && f <= 8'd105) b = 8'd24;
    else if (f == 8'd106) b = 8'd12;
    else if (f == 8'd107) b = 8'd32;
    else if (f >= 8'd108 && f <= 8'd109) b = 8'd64;
    else if (f == 8'd110) b = 8'd12;
    else if (f >= 8'd111 && f <= 8'd113) b = 8'd8;
    else if (f >= 8'd114 && f <= 8'd115) b = 8'd16;
    else if (f >= 8'd130 && f <= 8'd131) b = 8'd16;
    else if (f == 8'd132) b = 8'd24;
    return b;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/dmc_mul.sv
`default_nettype none

module dmc_mul (
  input  logic                       clk_i,
  input  logic [dmc_pkg::MulAW-1:0]  a_i,
  input  logic [dmc_pkg::MulBW-1:0]  b_i,
  output logic [dmc_pkg::MulPW-1:0]  p_o
);
  import dmc_pkg::*;

  logic [MulPW-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= MulPW'(a_i) * MulPW'(b_i);
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

FILE: rtl/dds_mip_chain_layout.sv
`default_nettype none
// channel  | valid        | stall        | payload
// ---------+--------------+--------------+---------------------------
// input    | in_valid_i   | in_stall_o   | in_item_i  (dmc_pkg::in_t)
// output   | out_valid_o  | out_stall_i  | out_item_o (dmc_pkg::out_t)
//
// Each mip level steps through S_ROW, S_SLICE, S_LOAD on the shared 20x16
// multiplier: row (w*bpp or blocks*block bytes), slice (row*height or
// row*block rows), then load of the output register (alone on a failure).
// Reset clears the sequencer and the output valid; no clearing pass.
// Output stalls hold the sequencer only when the next result is ready.

module dds_mip_chain_layout #(
  parameter int MAX_LEVELS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  dmc_pkg::in_t  in_item_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output dmc_pkg::out_t out_item_o
);
  import dmc_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ROW,
    S_SLICE,
    S_LOAD
  } state_e;

  state_e               state_q;
  logic                 ext_q;
  logic [7:0]           opb_q;
  logic [WidthW-1:0]    w_q, h_q;
  logic [LevelCntW-1:0] lvl_q, n_q;
  logic [OffsetW-1:0]   off_q;
  logic [RowW-1:0]      row_q;
  logic [2:0]           status_q;
  out_t                 out_q;
  logic                 out_valid_q;

  logic [MulAW-1:0]     mul_a;
  logic [MulBW-1:0]     mul_b;
  logic [MulPW-1:0]     mul_p;
  logic [WidthW:0]      w_p3, h_p3;
  logic [WidthW-2:0]    bw, bh;
  logic [MulPW-1:0]     p_rnd;
  logic [RowW-1:0]      row_now;
  logic                 in_acc;
  logic                 slot_free;
  logic                 load_go;
  logic                 is_last;
  logic [2:0]           dec_status;
  logic                 dec_ext;
  logic [7:0]           dec_opb;
  logic [LevelCntW-1:0] dec_n;
  logic [WidthW-1:0]    w_half, h_half;

  dmc_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  assign w_p3    = {1'b0, w_q} + 17'd3;
  assign h_p3    = {1'b0, h_q} + 17'd3;
  assign bw      = w_p3[WidthW:2];
  assign bh      = h_p3[WidthW:2];
  assign p_rnd   = mul_p + MulPW'(7);
  assign row_now = ext_q ? p_rnd[RowW+2:3] : mul_p[RowW-1:0];

  // while waiting to load, keep recomputing the slice so the product holds
  always_comb begin
    if (state_q == S_SLICE || state_q == S_LOAD) begin
      mul_a = (state_q == S_SLICE) ? row_now : row_q;
      mul_b = ext_q ? h_q : {1'b0, bh};
    end else begin
      mul_a = ext_q ? {4'b0, w_q} : {5'b0, bw};
      mul_b = {8'b0, opb_q};
    end
  end

  // header decode
  always_comb begin
    dec_ext = 1'b0;
    dec_opb = BLOCK_BYTES_DXTN;
    if (!in_item_i.fourcc_present) begin
      dec_status = ST_NO_FCC;
    end else if (in_item_i.fourcc_code == CODE_DXT1) begin
      dec_status = ST_OK;
      dec_opb    = BLOCK_BYTES_DXT1;
    end else if (in_item_i.fourcc_code == CODE_DXT2 ||
                 in_item_i.fourcc_code == CODE_DXT3 ||
                 in_item_i.fourcc_code == CODE_DXT4 ||
                 in_item_i.fourcc_code == CODE_DXT5) begin
      dec_status = ST_OK;
    end else if (in_item_i.fourcc_code == CODE_DX10) begin
      dec_status = ST_OK;
      dec_ext    = 1'b1;
      dec_opb    = dxgi_bits(in_item_i.pix_format);
    end else begin
      dec_status = ST_BAD_FCC;
    end
    if (dec_status == ST_OK && !in_item_i.has_linear_size) begin
      dec_status = ST_NO_LIN;
    end else if (dec_status == ST_OK && in_item_i.mip_count == '0) begin
      dec_status = ST_NO_LVL;
    end
    if (int'(in_item_i.mip_count) > MAX_LEVELS) begin
      dec_n = LevelCntW'(MAX_LEVELS);
    end else begin
      dec_n = in_item_i.mip_count;
    end
  end

  assign in_acc    = in_valid_i && (state_q == S_IDLE);
  assign slot_free = !out_valid_q || !out_stall_i;
  assign load_go   = (state_q == S_LOAD) && slot_free;
  assign is_last   = (status_q != ST_OK) || (lvl_q == n_q - 1'b1);
  assign w_half    = (w_q[WidthW-1:1] == '0) ? WidthW'(1) : {1'b0, w_q[WidthW-1:1]};
  assign h_half    = (h_q[WidthW-1:1] == '0) ? WidthW'(1) : {1'b0, h_q[WidthW-1:1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ext_q       <= 1'b0;
      opb_q       <= '0;
      w_q         <= WidthW'(1);
      h_q         <= WidthW'(1);
      lvl_q       <= '0;
      n_q         <= '0;
      off_q       <= '0;
      row_q       <= '0;
      status_q    <= ST_OK;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load_go) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            status_q <= dec_status;
            ext_q    <= dec_ext;
            opb_q    <= dec_opb;
            w_q      <= (in_item_i.width == '0) ? WidthW'(1) : in_item_i.width;
            h_q      <= (in_item_i.height == '0) ? WidthW'(1) : in_item_i.height;
            n_q      <= dec_n;
            lvl_q    <= '0;
            off_q    <= dec_ext ? EXT_OFFSET : BASE_OFFSET;
            state_q  <= (dec_status == ST_OK) ? S_ROW : S_LOAD;
          end
        end
        S_ROW: begin
          state_q <= S_SLICE;
        end
        S_SLICE: begin
          row_q   <= row_now;
          state_q <= S_LOAD;
        end
        S_LOAD: begin
          if (load_go) begin
            out_q.status <= status_q;
            out_q.last   <= is_last;
            if (status_q == ST_OK) begin
              out_q.level        <= lvl_q[3:0];
              out_q.level_offset <= off_q;
              out_q.row_size     <= row_q;
              out_q.slice_size   <= mul_p[SliceW-1:0];
            end else begin
              out_q.level        <= '0;
              out_q.level_offset <= '0;
              out_q.row_size     <= '0;
              out_q.slice_size   <= '0;
            end
            off_q <= off_q + OffsetW'(mul_p[SliceW-1:0]);
            w_q   <= w_half;
            h_q   <= h_half;
            lvl_q <= lvl_q + 1'b1;
            state_q <= is_last ? S_IDLE : S_ROW;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  a_err_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.status != ST_OK |-> out_item_o.last &&
      out_item_o.level == '0 && out_item_o.slice_size == '0)
    else $error("failure status not a single empty result");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("sequencer took an item without going busy");

  a_ok_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.status == ST_OK && out_item_o.level == '0 |->
      out_item_o.level_offset == BASE_OFFSET ||
      out_item_o.level_offset == EXT_OFFSET)
    else $error("first level offset is not a header size");

endmodule

`default_nettype wire

FILE: bench/dds_mip_chain_layout_tb.sv
module dds_mip_chain_layout_tb;
  import dmc_pkg::*;

  localparam int MaxLevels  = 16;
  localparam int IdleLimit  = 2000;
  localparam int DrainTail  = 64;
  localparam int RandomHdrs = 405;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  in_t  in_item_i;
  logic out_valid_o;
  logic out_stall_i;
  out_t out_item_o;

  out_t levels_due[$];
  bit   no_gaps;
  int   mismatches;
  int   n_headers;
  int   n_status;
  int   n_levels;
  int   idle_cycles;

  dds_mip_chain_layout #(
    .MAX_LEVELS(MaxLevels)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // bits per pixel of the extended-header formats, 0 where none is defined
  function automatic int unsigned pixel_bits(input logic [7:0] fmt);
    int f;
    f = fmt;
    if (f == 0) return 0;
    if (f <= 4) return 128;
    if (f <= 8) return 96;
    if (f <= 22) return 64;
    if (f <= 47) return 32;
    if (f <= 59) return 16;
    if (f <= 65) return 8;
    if (f == 66) return 1;
    if (f <= 69) return 32;
    if (f <= 72) return 4;
    if (f <= 78) return 8;
    if (f <= 81) return 4;
    if (f <= 84) return 8;
    if (f <= 86) return 16;
    if (f <= 93) return 32;
    if (f <= 99) return 8;
    if (f <= 101) return 32;
    if (f == 102) return 64;
    if (f == 103 || f == 106 || f == 110) return 12;
    if (f == 104 || f == 105) return 24;
    if (f == 107) return 32;
    if (f == 108 || f == 109) return 64;
    if (f >= 111 && f <= 113) return 8;
    if (f == 114 || f == 115) return 16;
    if (f == 130 || f == 131) return 16;
    if (f == 132) return 24;
    return 0;
  endfunction

  function automatic void predict_levels(input in_t hdr);
    out_t        r;
    logic [63:0] w;
    logic [63:0] h;
    logic [63:0] unit;
    logic [63:0] row;
    logic [63:0] slice;
    logic [63:0] off;
    int unsigned n;
    int unsigned lv;
    bit          ext;
    bit          known;
    r      = '0;
    r.last = 1'b1;
    ext    = (hdr.fourcc_code == CODE_DX10);
    known  = 1'b1;
    unit   = 0;
    if (hdr.fourcc_code == CODE_DXT1) unit = 8;
    else if (hdr.fourcc_code == CODE_DXT2 || hdr.fourcc_code == CODE_DXT3 ||
             hdr.fourcc_code == CODE_DXT4 || hdr.fourcc_code == CODE_DXT5) unit = 16;
    else if (ext) unit = pixel_bits(hdr.pix_format);
    else known = 1'b0;

    r.status = ST_OK;
    if (!hdr.fourcc_present) r.status = ST_NO_FCC;
    else if (!known) r.status = ST_BAD_FCC;
    else if (!hdr.has_linear_size) r.status = ST_NO_LIN;
    else if (hdr.mip_count == 0) r.status = ST_NO_LVL;
    if (r.status != ST_OK) begin
      levels_due.push_back(r);
      n_status++;
      return;
    end

    n   = (hdr.mip_count > MaxLevels) ? MaxLevels : hdr.mip_count;
    w   = (hdr.width == 0) ? 64'd1 : 64'(hdr.width);
    h   = (hdr.height == 0) ? 64'd1 : 64'(hdr.height);
    off = ext ? 64'(EXT_OFFSET) : 64'(BASE_OFFSET);
    for (lv = 0; lv < n; lv++) begin
      if (ext) begin
        row   = (w * unit + 7) >> 3;
        slice = row * h;
      end else begin
        // DXT: 4x4 blocks, row is one block row
        row   = ((w + 3) >> 2) * unit;
        slice = ((h + 3) >> 2) * row;
      end
      r.status       = ST_OK;
      r.level        = 4'(lv);
      r.level_offset = off[36:0];
      r.row_size     = row[19:0];
      r.slice_size   = slice[35:0];
      r.last         = (lv + 1 == n);
      levels_due.push_back(r);
      off = off + slice;
      w   = (w > 1) ? (w >> 1) : 64'd1;
      h   = (h > 1) ? (h >> 1) : 64'd1;
    end
  endfunction

  function automatic in_t mk_hdr(input bit fcc, input logic [31:0] code,
                                 input logic [7:0] fmt, input bit lin,
                                 input logic [15:0] w, input logic [15:0] h,
                                 input logic [4:0] n);
    in_t hdr;
    hdr.fourcc_present  = fcc;
    hdr.fourcc_code     = code;
    hdr.pix_format      = fmt;
    hdr.has_linear_size = lin;
    hdr.width           = w;
    hdr.height          = h;
    hdr.mip_count       = n;
    return hdr;
  endfunction

  // called and returns at a falling edge
  task automatic send_header(input in_t hdr);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 14);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= hdr;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_levels(hdr);
    n_headers++;
    @(negedge clk_i);
  endtask

  // receiver side: random hold-off before taking each item
  initial begin
    int gap;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      gap = no_gaps ? 0 : $urandom_range(0, 14);
      if (gap != 0) begin
        out_stall_i <= 1'b1;
        repeat (gap) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      @(negedge clk_i);
    end
  end

  function automatic void cmp_field(input string name, input logic [63:0] want,
                                    input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (levels_due.size() == 0) begin
        $error("result with no header pending: level %0d offset %0d",
               out_item_o.level, out_item_o.level_offset);
        mismatches++;
      end else begin
        want = levels_due.pop_front();
        cmp_field("status", want.status, out_item_o.status);
        cmp_field("level", want.level, out_item_o.level);
        cmp_field("level_offset", want.level_offset, out_item_o.level_offset);
        cmp_field("row_size", want.row_size, out_item_o.row_size);
        cmp_field("slice_size", want.slice_size, out_item_o.slice_size);
        cmp_field("last", want.last, out_item_o.last);
        n_levels++;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $error("no item moved for %0d cycles, %0d results pending",
             IdleLimit, levels_due.size());
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // failure codes, including the check order when several apply
  task automatic test_status_codes();
    send_header(mk_hdr(1'b0, CODE_DXT1, 8'd0, 1'b1, 16'd64, 16'd64, 5'd3));
    send_header(mk_hdr(1'b1, 32'hFFFF_FFFF, 8'd2, 1'b1, 16'd8, 16'd8, 5'd2));
    send_header(mk_hdr(1'b1, 32'h0000_0000, 8'd2, 1'b1, 16'd8, 16'd8, 5'd2));
    send_header(mk_hdr(1'b1, CODE_DXT1, 8'd0, 1'b0, 16'd16, 16'd16, 5'd4));
    send_header(mk_hdr(1'b1, CODE_DXT5, 8'd0, 1'b1, 16'd16, 16'd16, 5'd0));
    send_header(mk_hdr(1'b0, 32'h1234_5678, 8'd255, 1'b0, 16'd1, 16'd1, 5'd0));
    send_header(mk_hdr(1'b1, CODE_DX10, 8'd28, 1'b0, 16'd4, 16'd4, 5'd0));
  endtask

  // block-compressed codes at the size and level extremes
  task automatic test_dxt_blocks();
    send_header(mk_hdr(1'b1, CODE_DXT1, 8'd0, 1'b1, 16'hFFFF, 16'hFFFF, 5'd16));
    send_header(mk_hdr(1'b1, CODE_DXT2, 8'd255, 1'b1, 16'd1, 16'd1, 5'd1));
    send_header(mk_hdr(1'b1, CODE_DXT3, 8'd7, 1'b1, 16'd5, 16'd3, 5'd31));
    send_header(mk_hdr(1'b1, CODE_DXT4, 8'd0, 1'b1, 16'hFFFF, 16'd1, 5'd16));
    send_header(mk_hdr(1'b1, CODE_DXT5, 8'd0, 1'b1, 16'd1, 16'hFFFF, 5'd17));
  endtask

  // extended header: widest, narrowest, odd and missing table entries
  task automatic test_dx10_formats();
    send_header(mk_hdr(1'b1, CODE_DX10, 8'd2, 1'b1, 16'hFFFF, 16'hFFFF, 5'd16));
    send_header(mk_hdr(1'b1, CODE_DX10, 8'd66, 1'b1, 16'd13, 16'd7, 5'd5));
    send_header(mk_hdr(1'b1, CODE_DX10, 8'd103, 1'b1, 16'hFFFF, 16'd3, 5'd16));
    send_header(mk_hdr(1'b1, CODE_DX10, 8'd0, 1'b1, 16'd32, 16'd32, 5'd3));
    send_header(mk_hdr(1'b1, CODE_DX10, 8'd255, 1'b1, 16'd32, 16'd32, 5'd2));
    send_header(mk_hdr(1'b1, CODE_DX10, 8'd116, 1'b1, 16'd9, 16'd9, 5'd2));
    send_header(mk_hdr(1'b1, CODE_DX10, 8'd132, 1'b1, 16'd3, 16'd5, 5'd4));
  endtask

  // zero sizes count as 1; non-square chains clamp one axis early
  task automatic test_size_clamp();
    send_header(mk_hdr(1'b1, CODE_DXT1, 8'd0, 1'b1, 16'd0, 16'd12, 5'd3));
    send_header(mk_hdr(1'b1, CODE_DX10, 8'd28, 1'b1, 16'd12, 16'd0, 5'd3));
    send_header(mk_hdr(1'b1, CODE_DX10, 8'd28, 1'b1, 16'd256, 16'd16, 5'd16));
    send_header(mk_hdr(1'b1, CODE_DXT1, 8'd0, 1'b1, 16'd1023, 16'd777, 5'd11));
  endtask

  function automatic logic [15:0] rand_size();
    case ($urandom_range(0, 3))
      0: return 16'($urandom_range(1, 65535));
      1: return 16'($urandom_range(1, 16));
      2: return 16'(1 << $urandom_range(0, 15));
      default: return 16'($urandom_range(1, 300));
    endcase
  endfunction

  // mostly well-formed headers, some noise and broken ones
  task automatic test_random_headers(input int count);
    in_t hdr;
    int  sel;
    int  k;
    for (k = 0; k < count; k++) begin
      no_gaps = (k % 100) >= 80;
      hdr.fourcc_present  = 1'b1;
      hdr.has_linear_size = 1'b1;
      hdr.width           = rand_size();
      hdr.height          = rand_size();
      hdr.mip_count       = 5'($urandom_range(1, 16));
      hdr.pix_format      = ($urandom_range(0, 4) == 0) ? 8'($urandom) :
                            8'($urandom_range(1, 132));
      case ($urandom_range(0, 7))
        0: hdr.fourcc_code = CODE_DXT1;
        1: hdr.fourcc_code = CODE_DXT2;
        2: hdr.fourcc_code = CODE_DXT3;
        3: hdr.fourcc_code = CODE_DXT4;
        4: hdr.fourcc_code = CODE_DXT5;
        default: hdr.fourcc_code = CODE_DX10;
      endcase
      sel = $urandom_range(0, 99);
      if (sel < 5) begin
        hdr.fourcc_present = 1'b0;
        hdr.fourcc_code    = $urandom;
      end else if (sel < 10) begin
        hdr.fourcc_code = $urandom;
      end else if (sel < 13) begin
        // near miss on the code
        hdr.fourcc_code = hdr.fourcc_code ^ (32'd1 << $urandom_range(0, 31));
      end else if (sel < 17) begin
        hdr.has_linear_size = 1'b0;
      end else if (sel < 20) begin
        hdr.mip_count = 5'd0;
      end else if (sel < 23) begin
        hdr.mip_count = 5'($urandom_range(17, 31));
      end else if (sel < 24) begin
        if ($urandom_range(0, 1)) hdr.width = 16'd0;
        else hdr.height = 16'd0;
      end
      send_header(hdr);
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_item_i   = '0;
    no_gaps     = 1'b0;
    mismatches  = 0;
    n_headers   = 0;
    n_status    = 0;
    n_levels    = 0;
    idle_cycles = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_status_codes();
    test_dxt_blocks();
    test_dx10_formats();
    test_size_clamp();
    test_random_headers(RandomHdrs);

    in_valid_i <= 1'b0;
    while (levels_due.size() != 0) @(posedge clk_i);
    repeat (DrainTail) @(posedge clk_i);

    $display("Ran %0d headers (%0d ending in a failure status), %0d results checked,",
             n_headers, n_status, n_levels);
    $display("covering DXT1..DXT5 and extended formats with random input and output stalls");
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/dmc_pkg.sv
rtl/dmc_mul.sv
rtl/dds_mip_chain_layout.sv
bench/dds_mip_chain_layout_tb.sv
